@@ design/rlp_pkg.sv @@
// ----------------------------------------------------------------------------
// rlp_pkg
// shared types and constants for the rlp header and scalar encoder
// ----------------------------------------------------------------------------
`default_nettype none

package rlp_pkg;

  // request codes carried on the func field
  typedef enum logic [1:0] {
    FN_INT  = 2'd0,
    FN_STR  = 2'd1,
    FN_LIST = 2'd2
  } func_e;

  localparam logic [7:0] STR_OFF     = 8'h80;
  localparam logic [7:0] LIST_OFF    = 8'hc0;
  localparam logic [7:0] LONG_BASE   = 8'd55;
  localparam logic [6:0] SHORT_LIMIT = 7'd56;
  localparam int unsigned VAL_BYTES  = 8;

  // one encoding ready for the byte serializer
  typedef struct packed {
    logic [7:0]  hdr;   // first byte
    logic [63:0] data;  // payload bytes, most significant first
    logic [3:0]  cnt;   // payload bytes that follow the first byte
  } pkt_t;

endpackage

`default_nettype wire

@@ design/rlp_in_if.sv @@
// ----------------------------------------------------------------------------
// rlp_in_if
// request channel: func, value and first data byte
// ----------------------------------------------------------------------------
`default_nettype none

interface rlp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [63:0] value;
  logic [7:0]  first_byte;

  modport source (output valid, output func, output value, output first_byte, input ready);
  modport sink   (input valid, input func, input value, input first_byte, output ready);
endinterface

`default_nettype wire

@@ design/rlp_out_if.sv @@
// ----------------------------------------------------------------------------
// rlp_out_if
// encoded byte channel with end marker
// ----------------------------------------------------------------------------
`default_nettype none

interface rlp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

`default_nettype wire

@@ design/rlp_ser.sv @@
// ----------------------------------------------------------------------------
// rlp_ser
// byte serializer: header byte, then payload bytes, last marked
// ----------------------------------------------------------------------------
`default_nettype none

module rlp_ser (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             pkt_valid_i,
  input  rlp_pkg::pkt_t   pkt_i,
  output logic            pkt_ready_o,
  rlp_out_if.source       out_o
);

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_last_q, out_last_d;
  logic [63:0] sh_q, sh_d;
  logic [3:0]  rem_q, rem_d;
  logic        advance;

  // output register free or being drained this cycle
  assign advance     = !out_valid_q || out_o.ready;
  assign pkt_ready_o = advance && (rem_q == 4'd0);

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    sh_d        = sh_q;
    rem_d       = rem_q;
    if (advance) begin
      if (rem_q != 4'd0) begin
        // next payload byte
        out_valid_d = 1'b1;
        out_byte_d  = sh_q[63:56];
        out_last_d  = (rem_q == 4'd1);
        sh_d        = {sh_q[55:0], 8'h00};
        rem_d       = rem_q - 4'd1;
      end else if (pkt_valid_i) begin
        out_valid_d = 1'b1;
        out_byte_d  = pkt_i.hdr;
        out_last_d  = (pkt_i.cnt == 4'd0);
        sh_d        = pkt_i.data;
        rem_d       = pkt_i.cnt;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rem_q       <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      rem_q       <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    sh_q       <= sh_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.last     = out_last_q;

endmodule

`default_nettype wire

@@ design/rlp_header_and_scalar_encoder_top.sv @@
// ----------------------------------------------------------------------------
// rlp_header_and_scalar_encoder_top
// rlp encoder for 64-bit integers and string or list headers
// ----------------------------------------------------------------------------
// path: a request moves through the stage 1, 2 and 3 registers, and its first
//   byte then leaves the serializer's output register
// throughput: one request a cycle enters the pipe while no stage stalls; the
//   serializer sends a header and n payload bytes (0..8) before the next request
// reset: rst_ni clears every valid bit and the serializer's byte count;
//   payload registers are not reset
// ----------------------------------------------------------------------------
`default_nettype none

module rlp_header_and_scalar_encoder_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  rlp_in_if.sink     in_i,
  rlp_out_if.source  out_o
);

  // --------------------------------------------------------------------------
  // stage 1: request register
  // --------------------------------------------------------------------------
  logic        s1_valid_q;
  logic [1:0]  s1_func_q;
  logic [63:0] s1_value_q;
  logic [7:0]  s1_first_q;
  logic        s1_ready;

  // --------------------------------------------------------------------------
  // stage 2: byte count and range flags
  // --------------------------------------------------------------------------
  logic        s2_valid_q;
  logic [1:0]  s2_func_q;
  logic [63:0] s2_value_q;
  logic [7:0]  s2_first_q;
  logic [3:0]  s2_n_q, s2_n_d;
  logic        s2_lt128_q, s2_lt56_q, s2_single_q;
  logic        s2_ready;

  // --------------------------------------------------------------------------
  // stage 3: finished encoding waiting for the serializer
  // --------------------------------------------------------------------------
  logic          s3_valid_q;
  rlp_pkg::pkt_t s3_pkt_q, s3_pkt_d;
  logic          s3_ready;
  logic          pkt_ready;

  // backpressure chain: a stage takes new data when empty or when it drains
  assign s3_ready   = !s3_valid_q || pkt_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_i.ready = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready) begin
      s1_func_q  <= in_i.func;
      s1_value_q <= in_i.value;
      s1_first_q <= in_i.first_byte;
    end
  end

  // minimal big-endian byte count: index of the highest nonzero byte plus one
  always_comb begin
    s2_n_d = 4'd0;
    for (int i = 0; i < rlp_pkg::VAL_BYTES; i++) begin
      if (s1_value_q[8*i +: 8] != 8'h00) begin
        s2_n_d = 4'(i + 1);
      end
    end
  end

  // the unused request code produces no bytes, so it is dropped here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q && (s1_func_q == rlp_pkg::FN_INT ||
                                   s1_func_q == rlp_pkg::FN_STR ||
                                   s1_func_q == rlp_pkg::FN_LIST);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready) begin
      s2_func_q   <= s1_func_q;
      s2_value_q  <= s1_value_q;
      s2_first_q  <= s1_first_q;
      s2_n_q      <= s2_n_d;
      s2_lt128_q  <= (s1_value_q[63:7] == 57'd0);
      s2_lt56_q   <= (s1_value_q[63:6] == 58'd0) &&
                     (s1_value_q[5:0] < rlp_pkg::SHORT_LIMIT[5:0]);
      // one-byte string below 0x80 goes out as the byte itself
      s2_single_q <= (s1_value_q == 64'd1) && !s1_first_q[7];
    end
  end

  // header byte, payload byte count and left-aligned payload
  always_comb begin
    logic [7:0] off;
    off = (s2_func_q == rlp_pkg::FN_LIST) ? rlp_pkg::LIST_OFF : rlp_pkg::STR_OFF;
    // n == 0 shifts everything out, leaving an empty payload
    s3_pkt_d.data = s2_value_q << {4'd8 - s2_n_q, 3'b000};
    s3_pkt_d.cnt  = s2_n_q;
    s3_pkt_d.hdr  = off + rlp_pkg::LONG_BASE + {4'd0, s2_n_q};
    if (s2_func_q == rlp_pkg::FN_INT) begin
      if (s2_lt128_q && s2_n_q != 4'd0) begin
        s3_pkt_d.hdr = s2_value_q[7:0];
        s3_pkt_d.cnt = 4'd0;
      end else begin
        // zero encodes as the bare string offset with no payload; larger values get 0x80 plus n
        s3_pkt_d.hdr = rlp_pkg::STR_OFF + {4'd0, s2_n_q};
      end
    end else if (s2_func_q == rlp_pkg::FN_STR && s2_single_q) begin
      s3_pkt_d.hdr = s2_first_q;
      s3_pkt_d.cnt = 4'd0;
    end else if (s2_lt56_q) begin
      // short form header
      s3_pkt_d.hdr = off + s2_value_q[7:0];
      s3_pkt_d.cnt = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready) begin
      s3_pkt_q <= s3_pkt_d;
    end
  end

  // --------------------------------------------------------------------------
  // serializer and output register
  // --------------------------------------------------------------------------
  rlp_ser u_ser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_valid_i (s3_valid_q),
    .pkt_i       (s3_pkt_q),
    .pkt_ready_o (pkt_ready),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire
